// File: hdl/mandelbrot_pixel_colorizer_unit_defines.svh
// assertion macros shared by the mandelbrot pixel colorizer modules
`ifndef MANDELBROT_PIXEL_COLORIZER_UNIT_DEFINES_SVH
`define MANDELBROT_PIXEL_COLORIZER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPC_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define MPC_ASSERT(label, clk, rst, prop, msg)
`define MPC_ASSERT_NEXT(label, clk, rst, cond, nxt, msg)
`endif
`endif

// File: hdl/mpc_pkg.sv
// shared types, constants and helpers of the mandelbrot pixel colorizer
`timescale 1ns / 1ps
package mpc_pkg;

   localparam int DATA_BITS      = 32;
   localparam int STEP_BITS      = 31;
   localparam int ESC_BITS       = 31;
   localparam int ITER_BITS      = 7;
   localparam int COLOR_BITS     = 8;
   localparam int SAT_BITS       = 72;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DIVIDEND_BITS  = 15;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int MAX_ITER_DEF   = 127;

   localparam logic [ITER_BITS-1:0] ITER_MIN = ITER_BITS'(2);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_REAL     = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_IMAG     = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_REAL       = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_IMAG       = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ESCAPE_LIMIT    = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT = CSR_INDEX_BITS'(5);

   typedef struct packed {
      logic signed [DATA_BITS-1:0] origin_real;
      logic signed [DATA_BITS-1:0] origin_imag;
      logic [STEP_BITS-1:0]        step_real;
      logic [STEP_BITS-1:0]        step_imag;
      logic [ESC_BITS-1:0]         escape_limit;
      logic [ITER_BITS-1:0]        iteration_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_real:     DATA_BITS'(-402653184),
      origin_imag:     DATA_BITS'(201326592),
      step_real:       STEP_BITS'(840173),
      step_imag:       STEP_BITS'(840612),
      escape_limit:    ESC_BITS'(805306368),
      iteration_limit: ITER_BITS'(40)
   };

   // one classified pixel waiting for the iteration unit
   typedef struct packed {
      logic signed [DATA_BITS-1:0] c_re;
      logic signed [DATA_BITS-1:0] c_im;
      logic [ITER_BITS-1:0]        lim;
      logic                        skip;
   } work_type;

   typedef struct packed {
      logic [ITER_BITS-1:0] iterations;
      logic [ITER_BITS-1:0] lim;
   } iter_result_type;

   function automatic logic signed [DATA_BITS-1:0] sat_data(
      input logic signed [SAT_BITS-1:0] v
   );
      logic signed [SAT_BITS-1:0] hi;
      logic signed [SAT_BITS-1:0] lo;
      logic signed [DATA_BITS-1:0] res;
      hi = {{(SAT_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
      lo = {{(SAT_BITS-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};
      if (v > hi) begin
         res = hi[DATA_BITS-1:0];
      end else if (v < lo) begin
         res = lo[DATA_BITS-1:0];
      end else begin
         res = v[DATA_BITS-1:0];
      end
      return res;
   endfunction

endpackage

// File: hdl/mpc_if.sv
// request and response channel interfaces of the mandelbrot pixel colorizer
`timescale 1ns / 1ps
interface mpc_req_if #(
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] column;
   logic [COORD_BITS-1:0] row;
   modport source(output valid, column, row, input ready);
   modport sink(input valid, column, row, output ready);
endinterface

interface mpc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mpc_pkg::COLOR_BITS-1:0]       blue;
   logic [mpc_pkg::COLOR_BITS-1:0]       green;
   logic [mpc_pkg::COLOR_BITS-1:0]       red;
   logic [mpc_pkg::ITER_BITS-1:0]        iterations;
   modport source(output valid, blue, green, red, iterations, input ready);
   modport sink(input valid, blue, green, red, iterations, output ready);
endinterface

// File: hdl/mandelbrot_pixel_colorizer_unit.sv
// top level of the mandelbrot pixel colorizer: registers, front end, queue, iteration, colour
//
//   channel    dir  handshake            payload
//   req_chan   in   valid / ready        column, row
//   rsp_chan   out  valid / ready        blue, green, red, iterations
//   csr_*      in   csr_write_en         csr_index, csr_wdata
//
// each pass of the iteration unit is a multiply state, then an add-and-test state; the
// colour divider works on an escaped pixel (a black one skips it) while the iteration
// unit runs the next pixel, so the slower of the two sets the sustained pixel rate.
// synchronous reset loads the register defaults and empties the pipeline; no clearing pass.
// the two-entry queue and the output register let either side stall independently.
`timescale 1ns / 1ps
module mandelbrot_pixel_colorizer_unit #(
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = mpc_pkg::FRAC_BITS_DEF,
   parameter int MAX_ITER   = mpc_pkg::MAX_ITER_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mpc_req_if.sink                              req_chan,
   mpc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [mpc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mpc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   mpc_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      push_valid, push_ready;
   mpc_pkg::work_type         push_data;
   logic                      pop_valid, pop_ready;
   mpc_pkg::work_type         pop_data;
   logic                      res_valid, res_ready;
   mpc_pkg::iter_result_type  res_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            mpc_pkg::CSR_ORIGIN_REAL: begin
               cfg_in.origin_real = $signed(csr_wdata[mpc_pkg::DATA_BITS-1:0]);
            end
            mpc_pkg::CSR_ORIGIN_IMAG: begin
               cfg_in.origin_imag = $signed(csr_wdata[mpc_pkg::DATA_BITS-1:0]);
            end
            mpc_pkg::CSR_STEP_REAL: begin
               cfg_in.step_real = csr_wdata[mpc_pkg::STEP_BITS-1:0];
            end
            mpc_pkg::CSR_STEP_IMAG: begin
               cfg_in.step_imag = csr_wdata[mpc_pkg::STEP_BITS-1:0];
            end
            mpc_pkg::CSR_ESCAPE_LIMIT: begin
               cfg_in.escape_limit = csr_wdata[mpc_pkg::ESC_BITS-1:0];
            end
            mpc_pkg::CSR_ITERATION_LIMIT: begin
               cfg_in.iteration_limit = csr_wdata[mpc_pkg::ITER_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mpc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpc_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_ITER   (MAX_ITER)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   mpc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   mpc_iter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock        (clock),
      .reset        (reset),
      .escape_limit (cfg_ff.escape_limit),
      .pop_valid    (pop_valid),
      .pop_data     (pop_data),
      .pop_ready    (pop_ready),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .res_ready    (res_ready)
   );

   mpc_colour u_colour (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: hdl/mpc_front.sv
// front end: takes a pixel, forms c and classifies the item for the queue
`timescale 1ns / 1ps
module mpc_front #(
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF,
   parameter int MAX_ITER   = mpc_pkg::MAX_ITER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   mpc_req_if.sink           req_chan,
   input  mpc_pkg::cfg_type  cfg,
   output logic              push_valid,
   output mpc_pkg::work_type push_data,
   input  logic              push_ready
);

   localparam int PROD_BITS = COORD_BITS + mpc_pkg::STEP_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   logic                               valid_ff, valid_in;
   logic [PROD_BITS-1:0]               prod_re_ff, prod_im_ff;
   logic [mpc_pkg::ITER_BITS-1:0]      lim_ff, lim_in;
   logic                               skip_ff;
   logic signed [SUM_BITS-1:0]         re_sum, im_sum;
   logic                               take;

   assign req_chan.ready = !valid_ff || push_ready;
   assign take = req_chan.valid && req_chan.ready;

   // limit out of range acts as the nearest bound
   always_comb begin
      if (cfg.iteration_limit < mpc_pkg::ITER_MIN) begin
         lim_in = mpc_pkg::ITER_MIN;
      end else if (cfg.iteration_limit > mpc_pkg::ITER_BITS'(MAX_ITER)) begin
         lim_in = mpc_pkg::ITER_BITS'(MAX_ITER);
      end else begin
         lim_in = cfg.iteration_limit;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_re_ff <= PROD_BITS'(req_chan.column) * PROD_BITS'(cfg.step_real);
         prod_im_ff <= PROD_BITS'(req_chan.row) * PROD_BITS'(cfg.step_imag);
         lim_ff     <= lim_in;
         skip_ff    <= (cfg.escape_limit == '0);
      end
   end

   always_comb begin
      re_sum = SUM_BITS'($signed(cfg.origin_real)) + $signed({2'b00, prod_re_ff});
      im_sum = SUM_BITS'($signed(cfg.origin_imag)) - $signed({2'b00, prod_im_ff});
      push_data.c_re = mpc_pkg::sat_data(mpc_pkg::SAT_BITS'(re_sum));
      push_data.c_im = mpc_pkg::sat_data(mpc_pkg::SAT_BITS'(im_sum));
      push_data.lim  = lim_ff;
      push_data.skip = skip_ff;
   end

   assign push_valid = valid_ff;

endmodule

// File: hdl/mpc_fifo.sv
// two-entry queue between the front end and the iteration unit
`timescale 1ns / 1ps
`include "mandelbrot_pixel_colorizer_unit_defines.svh"
module mpc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mpc_pkg::work_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output mpc_pkg::work_type pop_data,
   input  logic              pop_ready
);

   localparam int DEPTH    = mpc_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   mpc_pkg::work_type     mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MPC_ASSERT(a_fifo_count_bound, clock, reset, count_ff <= CNT_FULL, "queue count overran depth")

endmodule

// File: hdl/mpc_iter.sv
// iteration unit: runs z = z*z + c on three multipliers, multiply then add per pass
`timescale 1ns / 1ps
`include "mandelbrot_pixel_colorizer_unit_defines.svh"
module mpc_iter #(
   parameter int FRAC_BITS = mpc_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mpc_pkg::ESC_BITS-1:0]    escape_limit,
   input  logic                            pop_valid,
   input  mpc_pkg::work_type               pop_data,
   output logic                            pop_ready,
   output logic                            res_valid,
   output mpc_pkg::iter_result_type        res_data,
   input  logic                            res_ready
);

   localparam int DW = mpc_pkg::DATA_BITS;
   localparam int PW = 2 * DW;
   localparam int IW = mpc_pkg::ITER_BITS;
   localparam int SW = mpc_pkg::SAT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [DW-1:0]    c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [DW-1:0]    z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic [IW-1:0]           lim_ff, lim_in, n_ff, n_in, n_next;
   logic signed [PW-1:0]    rr_ff, ii_ff, ri_ff;
   logic signed [PW-1:0]    diff;
   logic [PW-1:0]           quad, quad_hi;
   logic                    go_on;

   assign pop_ready           = (state_ff == ST_IDLE);
   assign res_valid           = (state_ff == ST_DONE);
   assign res_data.iterations = n_ff;
   assign res_data.lim        = lim_ff;

   // |z|^2 before the update; floor(quad / 2^F) < E is the exact test against E * 2^F
   always_comb begin
      quad    = $unsigned(rr_ff) + $unsigned(ii_ff);
      quad_hi = quad >> FRAC_BITS;
      diff    = rr_ff - ii_ff;
      n_next  = n_ff + IW'(1);
      go_on   = (n_next < lim_ff) && (quad_hi < PW'(escape_limit));
   end

   always_comb begin
      state_in = state_ff;
      c_re_in  = c_re_ff;
      c_im_in  = c_im_ff;
      z_re_in  = z_re_ff;
      z_im_in  = z_im_ff;
      lim_in   = lim_ff;
      n_in     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               c_re_in  = pop_data.c_re;
               c_im_in  = pop_data.c_im;
               lim_in   = pop_data.lim;
               z_re_in  = '0;
               z_im_in  = '0;
               n_in     = IW'(1);
               state_in = pop_data.skip ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            z_re_in  = mpc_pkg::sat_data(SW'(diff >>> FRAC_BITS) + SW'(c_re_ff));
            z_im_in  = mpc_pkg::sat_data(SW'(ri_ff >>> (FRAC_BITS - 1)) + SW'(c_im_ff));
            n_in     = n_next;
            state_in = go_on ? ST_MUL : ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      c_re_ff <= c_re_in;
      c_im_ff <= c_im_in;
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
      lim_ff  <= lim_in;
      n_ff    <= n_in;
      rr_ff   <= z_re_ff * z_re_ff;
      ii_ff   <= z_im_ff * z_im_ff;
      ri_ff   <= z_re_ff * z_im_ff;
   end

   `MPC_ASSERT(a_iter_below_limit, clock, reset, (state_ff == ST_ADD) |-> (n_ff < lim_ff), "pass started at the limit")
   `MPC_ASSERT_NEXT(a_iter_count_up, clock, reset, state_ff == ST_ADD, n_ff >= mpc_pkg::ITER_MIN, "count did not advance")
   `MPC_ASSERT(a_iter_done_range, clock, reset, (state_ff == ST_DONE) |-> (n_ff <= lim_ff && n_ff != '0), "final count out of range")

endmodule

// File: hdl/mpc_colour.sv
// colour unit: band and ramp divisions on a shared bit-serial divider, output register
`timescale 1ns / 1ps
`include "mandelbrot_pixel_colorizer_unit_defines.svh"
module mpc_colour (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   input  mpc_pkg::iter_result_type  res_data,
   output logic                      res_ready,
   mpc_rsp_if.source                 rsp_chan
);

   localparam int IW        = mpc_pkg::ITER_BITS;
   localparam int CW        = mpc_pkg::COLOR_BITS;
   localparam int DIV_BITS  = mpc_pkg::DIVIDEND_BITS;
   localparam int DCNT_BITS = $clog2(DIV_BITS);
   localparam int BAND_BITS = 3;
   localparam logic [DCNT_BITS-1:0] DCNT_LAST = DCNT_BITS'(DIV_BITS - 1);
   localparam logic [DIV_BITS-1:0]  BAND_SCALE = DIV_BITS'(7);

   localparam logic [BAND_BITS-1:0] BAND_0     = 3'd0;
   localparam logic [BAND_BITS-1:0] BAND_1     = 3'd1;
   localparam logic [BAND_BITS-1:0] BAND_2     = 3'd2;
   localparam logic [BAND_BITS-1:0] BAND_3     = 3'd3;
   localparam logic [BAND_BITS-1:0] BAND_4     = 3'd4;
   localparam logic [BAND_BITS-1:0] BAND_5     = 3'd5;
   localparam logic [BAND_BITS-1:0] BAND_BLACK = 3'd7;

   localparam logic [1:0] STAGE_BAND   = 2'd0;
   localparam logic [1:0] STAGE_FIRST  = 2'd1;
   localparam logic [1:0] STAGE_SECOND = 2'd2;

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_DIV  = 4'b0010,
      C_LOAD = 4'b0100,
      C_OUT  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              stage_ff, stage_in;
   logic [DCNT_BITS-1:0]    dcnt_ff, dcnt_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [IW-1:0]           rem_ff, rem_in;
   logic [IW-1:0]           lim_ff, lim_in, n_ff, n_in;
   logic                    black_ff, black_in;
   logic [BAND_BITS-1:0]    h_ff, h_in;
   logic [IW-1:0]           rem_keep_ff, rem_keep_in;
   logic [CW-1:0]           x1_ff, x1_in, x2_ff, x2_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CW-1:0]           blue_ff, green_ff, red_ff;
   logic [IW-1:0]           iter_ff;
   logic [CW-1:0]           blue_c, green_c, red_c;
   logic [IW:0]             partial;
   logic [IW+1:0]           trial;
   logic [BAND_BITS-1:0]    h_pick;
   logic [IW-1:0]           r_pick;
   logic [DIV_BITS-1:0]     numer;
   logic                    out_load;

   // numerator of a ramp division: remainder or its complement times the colour scale
   function automatic logic [DIV_BITS-1:0] band_numer(
      input logic [BAND_BITS-1:0] h,
      input logic [IW-1:0]        r,
      input logic [IW-1:0]        lim,
      input logic                 first
   );
      logic [IW-1:0] qn;
      logic [IW-1:0] a;
      logic [CW-1:0] k;
      qn = lim - r;
      case (h)
         BAND_0: begin
            a = r;
            k = first ? 8'd127 : 8'd255;
         end
         BAND_1: begin
            a = r;
            k = first ? 8'd255 : 8'd0;
         end
         BAND_2: begin
            a = qn;
            k = first ? 8'd255 : 8'd0;
         end
         BAND_3: begin
            a = qn;
            k = first ? 8'd127 : 8'd0;
         end
         BAND_4: begin
            a = qn;
            k = first ? 8'd63 : 8'd127;
         end
         BAND_5: begin
            a = r;
            k = first ? 8'd128 : 8'd0;
         end
         default: begin
            a = qn;
            k = first ? 8'd64 : 8'd128;
         end
      endcase
      return DIV_BITS'(a) * DIV_BITS'(k);
   endfunction

   assign res_ready = (state_ff == C_IDLE);
   assign out_load  = (state_ff == C_OUT) && (!out_valid_ff || rsp_chan.ready);

   // one restoring step per cycle
   always_comb begin
      partial = {rem_ff, quo_ff[DIV_BITS-1]};
      trial   = {1'b0, partial} - {2'b00, lim_ff};
      h_pick  = (stage_ff == STAGE_BAND) ? quo_ff[BAND_BITS-1:0] : h_ff;
      r_pick  = (stage_ff == STAGE_BAND) ? rem_ff : rem_keep_ff;
      numer   = band_numer(h_pick, r_pick, lim_ff, stage_ff == STAGE_BAND);
   end

   always_comb begin
      state_in    = state_ff;
      stage_in    = stage_ff;
      dcnt_in     = dcnt_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      lim_in      = lim_ff;
      n_in        = n_ff;
      black_in    = black_ff;
      h_in        = h_ff;
      rem_keep_in = rem_keep_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      case (state_ff)
         C_IDLE: begin
            if (res_valid) begin
               lim_in   = res_data.lim;
               n_in     = res_data.iterations;
               black_in = (res_data.iterations == res_data.lim);
               quo_in   = DIV_BITS'(res_data.iterations) * BAND_SCALE;
               rem_in   = '0;
               dcnt_in  = '0;
               stage_in = STAGE_BAND;
               state_in = (res_data.iterations == res_data.lim) ? C_OUT : C_DIV;
            end
         end
         C_DIV: begin
            if (trial[IW+1]) begin
               rem_in = partial[IW-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end else begin
               rem_in = trial[IW-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end
            dcnt_in = dcnt_ff + DCNT_BITS'(1);
            if (dcnt_ff == DCNT_LAST) begin
               state_in = C_LOAD;
            end
         end
         C_LOAD: begin
            rem_in  = '0;
            dcnt_in = '0;
            quo_in  = numer;
            case (stage_ff)
               STAGE_BAND: begin
                  h_in        = quo_ff[BAND_BITS-1:0];
                  rem_keep_in = rem_ff;
                  stage_in    = STAGE_FIRST;
                  state_in    = C_DIV;
               end
               STAGE_FIRST: begin
                  x1_in    = quo_ff[CW-1:0];
                  stage_in = STAGE_SECOND;
                  state_in = C_DIV;
               end
               default: begin
                  x2_in    = quo_ff[CW-1:0];
                  state_in = C_OUT;
               end
            endcase
         end
         C_OUT: begin
            if (out_load) begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_comb begin
      case (h_ff)
         BAND_0: begin
            blue_c  = x1_ff + 8'd128;
            green_c = x2_ff;
            red_c   = 8'd0;
         end
         BAND_1: begin
            blue_c  = 8'd255;
            green_c = 8'd255;
            red_c   = x1_ff;
         end
         BAND_2: begin
            blue_c  = x1_ff;
            green_c = 8'd255;
            red_c   = 8'd255;
         end
         BAND_3: begin
            blue_c  = 8'd0;
            green_c = x1_ff + 8'd128;
            red_c   = 8'd255;
         end
         BAND_4: begin
            blue_c  = 8'd0;
            green_c = x1_ff + 8'd64;
            red_c   = x2_ff + 8'd128;
         end
         BAND_5: begin
            blue_c  = x1_ff;
            green_c = 8'd64;
            red_c   = 8'd128;
         end
         default: begin
            blue_c  = 8'd128;
            green_c = x1_ff;
            red_c   = x2_ff;
         end
      endcase
      // point that never escaped
      if (black_ff) begin
         blue_c  = 8'd0;
         green_c = 8'd0;
         red_c   = 8'd0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      dcnt_ff     <= dcnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      lim_ff      <= lim_in;
      n_ff        <= n_in;
      black_ff    <= black_in;
      h_ff        <= h_in;
      rem_keep_ff <= rem_keep_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      if (out_load) begin
         blue_ff  <= blue_c;
         green_ff <= green_c;
         red_ff   <= red_c;
         iter_ff  <= n_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.blue       = blue_ff;
   assign rsp_chan.green      = green_ff;
   assign rsp_chan.red        = red_ff;
   assign rsp_chan.iterations = iter_ff;

   `MPC_ASSERT(a_colour_band_range, clock, reset, (state_ff == C_OUT && !black_ff) |-> (h_ff != BAND_BLACK), "escaped point fell in the black band")

endmodule

// File: tb/sv/mpc_pixel_compare.sv
// pixel colour predictor and response comparison for the mandelbrot pixel colorizer bench
`timescale 1ns / 1ps
module mpc_pixel_compare
   import mpc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   mpc_req_if                        req,
   mpc_rsp_if                        rsp,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        pixels_in_flight
);

   localparam int FRAC = FRAC_BITS_DEF;

   typedef enum int unsigned {
      BAND_BLUE_GREEN,
      BAND_WHITE,
      BAND_YELLOW,
      BAND_ORANGE,
      BAND_RED,
      BAND_PURPLE,
      BAND_FADE
   } band_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
      logic [ITER_BITS-1:0]  iterations;
   } pixel_type;

   cfg_type   cfg;
   pixel_type expected_pixels[$];

   function automatic longint clamp_s32(input longint v);
      longint res;
      res = v;
      if (v > 64'sd2147483647) begin
         res = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         res = -64'sd2147483648;
      end
      return res;
   endfunction

   function automatic pixel_type colour_pixel(
      input cfg_type                   c,
      input logic [COORD_BITS_DEF-1:0] col,
      input logic [COORD_BITS_DEF-1:0] row
   );
      longint      c_re, c_im, z_re, z_im, rr, ii, ri;
      logic [63:0] quad, bound;
      int unsigned lim, n, h, rem, qn;
      pixel_type   px;
      lim = c.iteration_limit;
      if (lim < 2) lim = 2;
      if (lim > MAX_ITER_DEF) lim = MAX_ITER_DEF;
      c_re = clamp_s32(longint'($signed(c.origin_real)) + longint'(col) * longint'(c.step_real));
      c_im = clamp_s32(longint'($signed(c.origin_imag)) - longint'(row) * longint'(c.step_imag));
      bound = 64'(c.escape_limit) << FRAC;
      z_re = 0;
      z_im = 0;
      quad = '0;
      n = 1;
      // quad is the squared magnitude before the update, and gates the pass after it
      while (n < lim && quad < bound) begin
         rr = z_re * z_re;
         ii = z_im * z_im;
         ri = z_re * z_im;
         quad = rr + ii;
         z_re = clamp_s32(((rr - ii) >>> FRAC) + c_re);
         z_im = clamp_s32((ri >>> (FRAC - 1)) + c_im);
         n++;
      end
      h   = (7 * n) / lim;
      rem = (7 * n) % lim;
      qn  = lim - rem;
      px  = '0;
      px.iterations = ITER_BITS'(n);
      if (n != lim) begin
         case (band_type'(h))
            BAND_BLUE_GREEN: begin
               px.blue  = COLOR_BITS'(rem * 127 / lim + 128);
               px.green = COLOR_BITS'(rem * 255 / lim);
            end
            BAND_WHITE: begin
               px.blue  = 8'd255;
               px.green = 8'd255;
               px.red   = COLOR_BITS'(rem * 255 / lim);
            end
            BAND_YELLOW: begin
               px.blue  = COLOR_BITS'(qn * 255 / lim);
               px.green = 8'd255;
               px.red   = 8'd255;
            end
            BAND_ORANGE: begin
               px.green = COLOR_BITS'(qn * 127 / lim + 128);
               px.red   = 8'd255;
            end
            BAND_RED: begin
               px.green = COLOR_BITS'(qn * 63 / lim + 64);
               px.red   = COLOR_BITS'(qn * 127 / lim + 128);
            end
            BAND_PURPLE: begin
               px.blue  = COLOR_BITS'(rem * 128 / lim);
               px.green = 8'd64;
               px.red   = 8'd128;
            end
            default: begin
               px.blue  = 8'd128;
               px.green = COLOR_BITS'(qn * 64 / lim);
               px.red   = COLOR_BITS'(qn * 128 / lim);
            end
         endcase
      end
      return px;
   endfunction

   always @(posedge clock) begin
      pixel_type got, want;
      if (reset) begin
         cfg = CFG_RESET;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ORIGIN_REAL:     cfg.origin_real     = csr_wdata;
               CSR_ORIGIN_IMAG:     cfg.origin_imag     = csr_wdata;
               CSR_STEP_REAL:       cfg.step_real       = csr_wdata[STEP_BITS-1:0];
               CSR_STEP_IMAG:       cfg.step_imag       = csr_wdata[STEP_BITS-1:0];
               CSR_ESCAPE_LIMIT:    cfg.escape_limit    = csr_wdata[ESC_BITS-1:0];
               CSR_ITERATION_LIMIT: cfg.iteration_limit = csr_wdata[ITER_BITS-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            expected_pixels.push_back(colour_pixel(cfg, req.column, req.row));
         end
         if (rsp.valid && rsp.ready) begin
            got = '{blue: rsp.blue, green: rsp.green, red: rsp.red, iterations: rsp.iterations};
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel: blue %0d green %0d red %0d iterations %0d",
                      got.blue, got.green, got.red, got.iterations);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                  mismatch_count++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, got.green);
                  mismatch_count++;
               end
               if (got.red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, got.red);
                  mismatch_count++;
               end
               if (got.iterations !== want.iterations) begin
                  $error("iterations: expected %0d, actual %0d", want.iterations,
                         got.iterations);
                  mismatch_count++;
               end
            end
         end
      end
      pixels_in_flight <= expected_pixels.size();
   end

endmodule

// File: tb/sv/tb_mandelbrot_pixel_colorizer_unit.sv
// stimulus and verdict for the mandelbrot pixel colorizer unit
`timescale 1ns / 1ps
module tb_mandelbrot_pixel_colorizer_unit;
   import mpc_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int RANDOM_PHASES = 12;
   localparam int NOISE_PHASE   = RANDOM_PHASES - 1;
   localparam int PHASE_ITEMS   = 95;
   localparam int Q_ONE         = 1 << FRAC_BITS_DEF;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = CSR_INDEX_BITS'(6);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = CSR_INDEX_BITS'(7);

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        idle_pct;
   int                        stall_pct;
   int                        cycle_count = 0;
   int                        mismatch_count;
   int                        pixels_in_flight;

   mpc_req_if req_chan();
   mpc_rsp_if rsp_chan();

   mandelbrot_pixel_colorizer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   mpc_pixel_compare pixel_compare (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_mandelbrot_pixel_colorizer_unit: FAIL");
         $finish;
      end
   end

   task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] col,
                             input logic [COORD_BITS_DEF-1:0] row);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.column <= col;
      req_chan.row    <= row;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off new items until every pixel in flight has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pixels_in_flight != 0);
   endtask

   // unused upper bits carry junk, and a spare index gets a write that must be ignored
   task automatic load_settings(input cfg_type s);
      logic [31:0] junk;
      junk = $urandom();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ORIGIN_REAL;
      csr_wdata    <= s.origin_real;
      @(posedge clock);
      csr_index    <= CSR_ORIGIN_IMAG;
      csr_wdata    <= s.origin_imag;
      @(posedge clock);
      csr_index    <= CSR_STEP_REAL;
      csr_wdata    <= {junk[31], s.step_real};
      @(posedge clock);
      csr_index    <= CSR_STEP_IMAG;
      csr_wdata    <= {junk[30], s.step_imag};
      @(posedge clock);
      csr_index    <= CSR_ESCAPE_LIMIT;
      csr_wdata    <= {junk[29], s.escape_limit};
      @(posedge clock);
      csr_index    <= CSR_ITERATION_LIMIT;
      csr_wdata    <= {junk[24:0], s.iteration_limit};
      @(posedge clock);
      csr_index    <= junk[0] ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata    <= $urandom();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // window of span pixels over roughly [-2, 1] x [-1.5, 1.5]
   task automatic pick_view(output cfg_type s, input int span);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) s.iteration_limit = ITER_BITS'($urandom_range(2, 48));
      else if (r == 7) s.iteration_limit = ITER_BITS'($urandom_range(49, 126));
      else if (r == 8) s.iteration_limit = ITER_BITS'(MAX_ITER_DEF);
      else s.iteration_limit = ITER_BITS'($urandom_range(0, 1));
      s.step_real   = STEP_BITS'((3 * Q_ONE) / span + $urandom_range(0, 1023));
      s.step_imag   = STEP_BITS'((3 * Q_ONE) / span + $urandom_range(0, 1023));
      s.origin_real = DATA_BITS'(-2 * Q_ONE + int'($urandom_range(0, Q_ONE / 2)));
      s.origin_imag = DATA_BITS'(3 * Q_ONE / 2 - int'($urandom_range(0, Q_ONE / 4)));
      r = $urandom_range(0, 9);
      if (r < 6) s.escape_limit = ESC_BITS'(4 * Q_ONE);
      else if (r < 9) s.escape_limit = ESC_BITS'($urandom_range(Q_ONE / 4, 7 * Q_ONE));
      else s.escape_limit = ESC_BITS'($urandom());
   endtask

   initial begin
      cfg_type                   s;
      int                        span;
      logic [COORD_BITS_DEF-1:0] col, row;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.column = '0;
      req_chan.row    = '0;
      idle_pct        = 0;
      stall_pct       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default view: corners, alternating bits, a point inside the set
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd480, 12'd240);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(12'd300, 12'd100);

      // zero escape limit: loop never runs
      wait_drained();
      s = CFG_RESET;
      s.escape_limit = '0;
      load_settings(s);
      send_pixel(12'd480, 12'd240);
      send_pixel(12'd4095, 12'd4095);

      // limit below range acts as two
      wait_drained();
      s.iteration_limit = '0;
      load_settings(s);
      send_pixel(12'd480, 12'd240);
      wait_drained();
      s.escape_limit    = CFG_RESET.escape_limit;
      s.iteration_limit = ITER_BITS'(1);
      load_settings(s);
      send_pixel(12'd480, 12'd240);
      send_pixel(12'd0, 12'd0);

      // largest limit and escape bound
      wait_drained();
      s = CFG_RESET;
      s.iteration_limit = ITER_BITS'(MAX_ITER_DEF);
      s.escape_limit    = '1;
      load_settings(s);
      send_pixel(12'd480, 12'd240);
      send_pixel(12'd0, 12'd0);

      // c and z saturation at both ends
      wait_drained();
      s.origin_real = 32'h7FFF_FFFF;
      s.origin_imag = 32'h8000_0000;
      s.step_real   = '1;
      s.step_imag   = '1;
      load_settings(s);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      wait_drained();
      s.origin_real = 32'h8000_0000;
      s.origin_imag = 32'h7FFF_FFFF;
      load_settings(s);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         span = 1 << $urandom_range(3, 7);
         pick_view(s, span);
         if (p == NOISE_PHASE) begin
            s.origin_real = $urandom();
            s.origin_imag = $urandom();
            s.step_real   = STEP_BITS'($urandom());
            s.step_imag   = STEP_BITS'($urandom());
         end
         load_settings(s);
         repeat (PHASE_ITEMS) begin
            // mostly inside the window, the rest anywhere in the coordinate range
            if ($urandom_range(0, 99) < 85) col = COORD_BITS_DEF'($urandom_range(0, span - 1));
            else col = COORD_BITS_DEF'($urandom());
            if ($urandom_range(0, 99) < 85) row = COORD_BITS_DEF'($urandom_range(0, span - 1));
            else row = COORD_BITS_DEF'($urandom());
            send_pixel(col, row);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_mandelbrot_pixel_colorizer_unit: PASS");
      end else begin
         $display("tb_mandelbrot_pixel_colorizer_unit: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mpc_pkg.sv
hdl/mpc_if.sv
hdl/mpc_front.sv
hdl/mpc_fifo.sv
hdl/mpc_iter.sv
hdl/mpc_colour.sv
hdl/mandelbrot_pixel_colorizer_unit.sv
tb/sv/mpc_pixel_compare.sv
tb/sv/tb_mandelbrot_pixel_colorizer_unit.sv
